/* src/sfr_pkg.sv */
// Shared types and constants for the streaming find-and-replace block.
package sfr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int WIN_W           = 8 * MAX_PATTERN;
    localparam int REPL_W          = 8 * MAX_REPLACEMENT;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_ADDR_W      = 5;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] REG_MATCH_PATTERN      = 2'd0;
    localparam logic [1:0] REG_MATCH_LENGTH       = 2'd1;
    localparam logic [1:0] REG_REPLACEMENT_TEXT   = 2'd2;
    localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    typedef struct packed {
        logic [WIN_W-1:0]  match_pattern;
        logic [3:0]        match_length;
        logic [REPL_W-1:0] replacement_text;
        logic [3:0]        replacement_length;
    } cfg_t;

    // One burst of output words: len bytes taken from data, lowest byte first.
    // A burst with len zero and done set is a bare end marker.
    typedef struct packed {
        logic             done;
        logic [3:0]       len;
        logic [WIN_W-1:0] data;
    } job_t;

endpackage

/* src/sfr_regs.sv */
// Configuration register file with an APB-style access port.
module sfr_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sfr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output sfr_pkg::cfg_t                  cfg
);
    import sfr_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = paddr[CFG_ADDR_W-1:3];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (index)
                REG_MATCH_PATTERN:      cfg_next.match_pattern      = pwdata[WIN_W-1:0];
                REG_MATCH_LENGTH:       cfg_next.match_length       = pwdata[3:0];
                REG_REPLACEMENT_TEXT:   cfg_next.replacement_text   = pwdata[REPL_W-1:0];
                REG_REPLACEMENT_LENGTH: cfg_next.replacement_length = pwdata[3:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.match_pattern      <= '0;
            cfg_reg.match_length       <= 4'd1;
            cfg_reg.replacement_text   <= '0;
            cfg_reg.replacement_length <= 4'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (index)
            REG_MATCH_PATTERN:
                prdata = CFG_DATA_W'(cfg_reg.match_pattern);
            REG_MATCH_LENGTH:
                prdata = CFG_DATA_W'(cfg_reg.match_length);
            REG_REPLACEMENT_TEXT:
                prdata = CFG_DATA_W'(cfg_reg.replacement_text);
            REG_REPLACEMENT_LENGTH:
                prdata = CFG_DATA_W'(cfg_reg.replacement_length);
            default:
                prdata = '0;
        endcase
    end

endmodule

/* src/sfr_front.sv */
// Front end: holds the pending window, matches it and turns each input word that yields output into a burst.
module sfr_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  sfr_pkg::cfg_t cfg,
    input  logic          accept,
    input  logic [7:0]    text_byte,
    input  logic          end_of_text,
    output logic          push,
    output sfr_pkg::job_t job
);
    import sfr_pkg::*;

    logic [WIN_W-1:0] window_reg;
    logic [WIN_W-1:0] window_next;
    logic [3:0]       count_reg;
    logic [3:0]       count_next;
    logic [WIN_W-1:0] new_win;
    logic [3:0]       new_cnt;
    logic [3:0]       plen;
    logic [3:0]       rlen;
    logic [3:0]       pop;
    logic             hit;

    always_comb begin
        if (cfg.match_length == 4'd0) begin
            plen = 4'd1;
        end else if (cfg.match_length > 4'(MAX_PATTERN)) begin
            plen = 4'(MAX_PATTERN);
        end else begin
            plen = cfg.match_length;
        end
        if (cfg.replacement_length > 4'(MAX_REPLACEMENT)) begin
            rlen = 4'(MAX_REPLACEMENT);
        end else begin
            rlen = cfg.replacement_length;
        end
    end

    always_comb begin
        new_win = window_reg;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (count_reg == 4'(i)) begin
                new_win[8*i +: 8] = text_byte;
            end
        end
        new_cnt = count_reg + 4'd1;

        hit = (new_cnt == plen);
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((4'(i) < plen) && (new_win[8*i +: 8] != cfg.match_pattern[8*i +: 8])) begin
                hit = 1'b0;
            end
        end

        if (new_cnt > plen) begin
            pop = new_cnt - plen + 4'd1;
        end else if ((new_cnt == plen) && !hit) begin
            pop = 4'd1;
        end else begin
            pop = 4'd0;
        end
        if (end_of_text && !hit) begin
            pop = new_cnt;
        end

        job.done = end_of_text;
        if (hit) begin
            job.len  = rlen;
            job.data = WIN_W'(cfg.replacement_text);
        end else begin
            job.len  = pop;
            job.data = new_win;
        end
        push = accept && ((job.len != 4'd0) || end_of_text);

        window_next = new_win >> {pop, 3'b000};
        if (hit || end_of_text) begin
            count_next = 4'd0;
        end else begin
            count_next = new_cnt - pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 4'd0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            window_reg <= window_next;
        end
    end

endmodule

/* src/sfr_queue.sv */
// Short burst queue between the front end and the output sequencer.
module sfr_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sfr_pkg::job_t push_job,
    input  logic          pop,
    output sfr_pkg::job_t head_job,
    output logic          not_empty,
    output logic          full
);
    import sfr_pkg::*;

    job_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign head_job  = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* src/sfr_back.sv */
// Back end: plays each queued burst out as a sequence of output words.
module sfr_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  sfr_pkg::job_t head_job,
    input  logic          not_empty,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast,
    output logic [1:0]    m_tuser
);
    import sfr_pkg::*;

    logic             valid_reg;
    logic [WIN_W-1:0] data_reg;
    logic [3:0]       left_reg;
    logic             present_reg;
    logic             done_reg;
    logic             out_accept;
    logic             is_last;

    assign out_accept = valid_reg && m_tready;
    assign is_last    = (left_reg == 4'd1);
    assign pop        = not_empty && (!valid_reg || (out_accept && is_last));

    assign m_tvalid = valid_reg;
    assign m_tdata  = present_reg ? data_reg[7:0] : 8'd0;
    assign m_tlast  = is_last;
    assign m_tuser  = {done_reg && is_last, present_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (out_accept && is_last) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg    <= head_job.data;
            present_reg <= (head_job.len != 4'd0);
            left_reg    <= (head_job.len == 4'd0) ? 4'd1 : head_job.len;
            done_reg    <= head_job.done;
        end else if (out_accept) begin
            data_reg <= data_reg >> 8;
            left_reg <= left_reg - 4'd1;
        end
    end

endmodule

/* src/stream_find_and_replace_core.sv */
// Top level of the streaming find-and-replace block.
// Text arrives one byte per word on the slave stream, with tlast on the final byte of a
// text, and leaves on the master stream with every leftmost non-overlapping occurrence of
// the configured pattern replaced. One input word is taken per cycle as long as the burst
// queue has room; the output sends one word per cycle while m_tready is high, and the
// four-entry queue absorbs the bursts of steps that yield several words before
// backpressure reaches the input. Master tlast marks the last word caused by one input
// word; tuser bit 1 marks the final word of a text, and a word with tuser bit 0 low is a
// bare end marker that carries no byte. Configuration is written through the APB port at
// byte addresses 0, 8, 16 and 24 and must only change while the block is idle.
module stream_find_and_replace_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sfr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // text_byte
    input  logic                           s_tlast,   // end_of_text
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // out_byte
    output logic                           m_tlast,   // run_last
    output logic [1:0]                     m_tuser    // text_done (bit 1), byte_present (bit 0)
);
    import sfr_pkg::*;

    cfg_t cfg;
    job_t push_job;
    job_t head_job;
    logic push;
    logic pop;
    logic not_empty;
    logic full;
    logic in_accept;

    assign s_tready  = !full;
    assign in_accept = s_tvalid && s_tready;

    sfr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .accept      (in_accept),
        .text_byte   (s_tdata),
        .end_of_text (s_tlast),
        .push        (push),
        .job         (push_job)
    );

    sfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head_job  (head_job),
        .not_empty (not_empty),
        .full      (full)
    );

    sfr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_job  (head_job),
        .not_empty (not_empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
